// ----- hdl/ptp_string_utf16_to_utf8_unit_macros.svh -----
// Assertion macros shared by the UTF-16LE to UTF-8 unit.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef PTP_STRING_UTF16_TO_UTF8_UNIT_MACROS_SVH
`define PTP_STRING_UTF16_TO_UTF8_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define U2U_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ptp_u2u_pkg.sv -----
// Package for the UTF-16LE to UTF-8 unit: payload types, job format,
// and the UTF-8 length and byte helpers. No dependencies.
`default_nettype none

package ptp_u2u_pkg;

  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2
  } out_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } ptp_u2u_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    out_kind_e  out_kind;
    logic       run_last;
  } ptp_u2u_out_t;

  // One job per input byte that yields results: either a marker or one
  // or two code points to expand.
  typedef struct packed {
    logic        is_mark;
    out_kind_e   mark_kind;
    logic [20:0] cp0;
    logic        has_cp1;
    logic [15:0] cp1;
  } ptp_u2u_job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h00007F) begin
      len = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      len = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [2:0] idx);
    logic [7:0] b;
    case (len)
      3'd1: begin
        b = cp[7:0];
      end
      3'd2: begin
        b = (idx == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        case (idx)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {2'b10, cp[17:12]};
          3'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ptp_u2u_front.sv -----
// Front end: string parser that assembles code units, pairs surrogates
// and issues expansion jobs. Depends on ptp_u2u_pkg.
`default_nettype none

module ptp_u2u_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire ptp_u2u_pkg::ptp_u2u_in_t  item_i,
  output logic                           job_valid_o,
  output ptp_u2u_pkg::ptp_u2u_job_t      job_o
);
  import ptp_u2u_pkg::*;

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  units_q, units_d;
  logic [7:0]  low_q, low_d;
  logic [9:0]  held_q, held_d;   // low ten bits of a held high surrogate
  logic        held_v_q, held_v_d;

  logic [15:0] unit;
  logic        unit_hi, unit_lo, keep;

  assign unit    = {item_i.data_byte, low_q};
  assign unit_hi = (unit[15:10] == 6'b110110);
  assign unit_lo = (unit[15:10] == 6'b110111);
  assign keep    = unit_hi && (units_q >= 8'd3);

  always_comb begin
    phase_d     = phase_q;
    units_d     = units_q;
    low_d       = low_q;
    held_d      = held_q;
    held_v_d    = held_v_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      case (phase_q)
        PH_LOW: begin
          low_d = item_i.data_byte;
          if (item_i.end_of_buffer) begin
            phase_d = PH_COUNT; units_d = '0; low_d = '0; held_d = '0; held_v_d = 1'b0;
            job_valid_o     = 1'b1;
            job_o.is_mark   = 1'b1;
            job_o.mark_kind = KIND_TRUNC;
          end else begin
            phase_d = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (units_q <= 8'd1) begin
            phase_d = PH_COUNT; units_d = '0; low_d = '0; held_d = '0; held_v_d = 1'b0;
            job_valid_o     = 1'b1;
            job_o.is_mark   = 1'b1;
            job_o.mark_kind = KIND_DONE;
          end else if (item_i.end_of_buffer) begin
            phase_d = PH_COUNT; units_d = '0; low_d = '0; held_d = '0; held_v_d = 1'b0;
            job_valid_o     = 1'b1;
            job_o.is_mark   = 1'b1;
            job_o.mark_kind = KIND_TRUNC;
          end else begin
            if (held_v_q && unit_lo) begin
              // surrogate pair -> supplementary code point
              job_valid_o = 1'b1;
              job_o.cp0   = 21'h010000 + {1'b0, held_q, unit[9:0]};
              held_v_d    = 1'b0;
              held_d      = '0;
            end else begin
              if (held_v_q) begin
                job_valid_o = 1'b1;
                job_o.cp0   = {5'b0, 6'b110110, held_q};
                if (!keep) begin
                  job_o.has_cp1 = 1'b1;
                  job_o.cp1     = unit;
                end
              end else if (!keep) begin
                job_valid_o = 1'b1;
                job_o.cp0   = {5'b0, unit};
              end
              held_v_d = keep;
              held_d   = keep ? unit[9:0] : '0;
            end
            units_d = units_q - 8'd1;
            phase_d = PH_LOW;
          end
        end
        default: begin
          phase_d = PH_COUNT; units_d = '0; low_d = '0; held_d = '0; held_v_d = 1'b0;
          if (item_i.data_byte == 8'd0) begin
            job_valid_o     = 1'b1;
            job_o.is_mark   = 1'b1;
            job_o.mark_kind = KIND_DONE;
          end else if (item_i.end_of_buffer) begin
            job_valid_o     = 1'b1;
            job_o.is_mark   = 1'b1;
            job_o.mark_kind = KIND_TRUNC;
          end else begin
            units_d = item_i.data_byte;
            phase_d = PH_LOW;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COUNT;
      units_q  <= '0;
      low_q    <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      units_q  <= units_d;
      low_q    <= low_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ptp_u2u_job_fifo.sv -----
// Short job queue between parser and byte expander.
// Depends on ptp_u2u_pkg and the unit's assertion macro header.
`default_nettype none
`include "ptp_string_utf16_to_utf8_unit_macros.svh"

module ptp_u2u_job_fifo (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire ptp_u2u_pkg::ptp_u2u_job_t  wr_job_i,
  output logic                            full_o,
  input  wire logic                       rd_en_i,
  output ptp_u2u_pkg::ptp_u2u_job_t       rd_job_o,
  output logic                            empty_o
);
  import ptp_u2u_pkg::*;

  ptp_u2u_job_t       mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] cnt_q;

  assign full_o   = (cnt_q == JobCntW'(JobDepth));
  assign empty_o  = (cnt_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `U2U_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= JobCntW'(JobDepth), "job count over depth")
  `U2U_ASSERT_NOW(a_no_overflow, wr_en_i, !full_o, "job written while queue full")
  `U2U_ASSERT_NOW(a_no_underflow, rd_en_i, !empty_o, "job read while queue empty")
  `U2U_ASSERT_NEXT(a_write_lands, wr_en_i && !rd_en_i, !empty_o, "write left queue empty")

endmodule

`default_nettype wire

// ----- hdl/ptp_u2u_back.sv -----
// Back end: expands one job into UTF-8 bytes or a marker, into the output
// register, one result per cycle while it frees. Depends on ptp_u2u_pkg.
`default_nettype none

module ptp_u2u_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ptp_u2u_pkg::ptp_u2u_job_t  job_i,
  input  wire logic                       job_empty_i,
  output logic                            job_pop_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output ptp_u2u_pkg::ptp_u2u_out_t       result_o
);
  import ptp_u2u_pkg::*;

  logic [2:0]   idx_q;
  logic         out_v_q;
  ptp_u2u_out_t out_q;

  logic [2:0]   n0, n1, total;
  logic         last, advance;
  ptp_u2u_out_t cur;

  assign n0    = utf8_len(job_i.cp0);
  assign n1    = job_i.has_cp1 ? utf8_len({5'b0, job_i.cp1}) : 3'd0;
  assign total = n0 + n1;
  assign last  = job_i.is_mark || (idx_q == total - 3'd1);

  always_comb begin
    cur = '0;
    cur.run_last = last;
    if (job_i.is_mark) begin
      cur.out_kind = job_i.mark_kind;
    end else begin
      cur.out_kind = KIND_BYTE;
      cur.out_byte = (idx_q < n0) ? utf8_byte(job_i.cp0, n0, idx_q)
                                  : utf8_byte({5'b0, job_i.cp1}, n1, idx_q - n0);
    end
  end

  // output register frees when empty or being taken this cycle
  assign advance   = !job_empty_i && (!out_v_q || pop_i);
  assign job_pop_o = advance && last;
  assign empty_o   = !out_v_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q <= last ? 3'd0 : idx_q + 3'd1;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ptp_string_utf16_to_utf8_unit.sv -----
// Top level of the UTF-16LE to UTF-8 unit: parser, job queue, byte expander.
// Depends on ptp_u2u_pkg, ptp_u2u_front, ptp_u2u_job_fifo, ptp_u2u_back.
`default_nettype none

// Transcodes a byte stream of length-prefixed UTF-16LE strings to UTF-8.
// Each string is a count byte and then that many little-endian code units;
// the last unit is a terminator that yields a single "finished" result
// (out_kind 1) and is not converted. Surrogate pairs become 4-byte
// sequences, unpaired surrogates 3-byte ones. end_of_buffer inside a
// string yields a single "truncated" result (out_kind 2); the consumer
// should drop that string. run_last marks the final result caused by an
// input byte, so results can be matched back to input transfers.
// Timing: an input transfer is taken every cycle while the four-entry job
// queue has room (full reflects that queue, so bytes can follow back to
// back). Each input byte that yields results becomes one job; the expander
// sends one result per cycle while its output register frees; a job yields
// 1 to 6 results (up to 4 bytes for one code point, up to 6 when a held
// surrogate is flushed with the next unit). The sustained rate is set by
// that byte-serial expander: ASCII text keeps up with one input byte per
// cycle; 3-byte text and flushed surrogates fall behind. A job enters the
// queue at the accepting edge; the expander writes its first result into
// the output register once it is free. If a job is waiting, a new result
// replaces the current one in the cycle it is popped; while a result waits
// for pop, the expander holds and the queue absorbs up to four jobs.

module ptp_string_utf16_to_utf8_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire ptp_u2u_pkg::ptp_u2u_in_t  item_i,
  output logic                           empty,
  input  wire logic                      pop,
  output ptp_u2u_pkg::ptp_u2u_out_t      result_o
);
  import ptp_u2u_pkg::*;

  logic         accept;
  logic         job_valid;
  ptp_u2u_job_t job_in, job_head;
  logic         job_full, job_empty, job_pop;

  // parser only advances when a job slot is guaranteed
  assign full   = job_full;
  assign accept = push && !job_full;

  ptp_u2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  ptp_u2u_job_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_valid),
    .wr_job_i (job_in),
    .full_o   (job_full),
    .rd_en_i  (job_pop),
    .rd_job_o (job_head),
    .empty_o  (job_empty)
  );

  ptp_u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
